/* design/efm_pkg.sv */
package efm_pkg;

    // Fixed field widths
    localparam int SHELF_W   = 16;
    localparam int STATUS_W  = 2;
    localparam int REPORT_W  = 8;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_STORED   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_SERVED   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_UNSERVED = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd3;

    // Event modes
    localparam logic MODE_PRODUCE = 1'b0;
    localparam logic MODE_CONSUME = 1'b1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [REPORT_W-1:0] dropped_count;
        logic [REPORT_W-1:0] occupancy;
        logic                all_served;
    } result_t;

endpackage

/* design/expiring_fifo_matcher.sv */
// Channel   Ports                                   Dir  Beat
// --------  --------------------------------------  ---  ----------------------------
// input     s_valid s_ready s_mode s_event_time     in   one produce or consume event
// result    m_valid m_ready m_status m_dropped_count out  one result per event
//           m_occupancy m_all_served
// config    cfg_valid cfg_ready cfg_data            in   shelf_life register write
//
// Sequence: a produce is accepted, then its result is loaded into the output
//   register. A consume walks the entries it pops, one entry per cycle, bound
//   by the single read port of the expiry RAM (registered read).
// Reset: aresetn synchronous, active low; clears pointers, count, shelf_life
//   and output valid, and sets the sticky flag. No clearing pass: RAM entries
//   are read only after being written.
// Stalls: a finished result sits in the output register while the next beat is
//   accepted; the following result waits until m_ready frees that register.
module expiring_fifo_matcher #(
    parameter int DEPTH     = 128,
    parameter int TIME_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // event input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_mode,
    input  logic [TIME_BITS-1:0]                s_event_time,
    // result output
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [efm_pkg::STATUS_W-1:0]        m_status,
    output logic [efm_pkg::REPORT_W-1:0]        m_dropped_count,
    output logic [efm_pkg::REPORT_W-1:0]        m_occupancy,
    output logic                                m_all_served,
    // shelf_life write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [efm_pkg::SHELF_W-1:0]         cfg_data
);

    // Expiry = time + shelf_life; wide enough for either operand plus carry.
    localparam int EXP_W = ((TIME_BITS > efm_pkg::SHELF_W) ? TIME_BITS
                                                            : efm_pkg::SHELF_W) + 1;
    localparam int PTR_W = $clog2(DEPTH);

    logic [efm_pkg::SHELF_W-1:0] shelf_reg;
    efm_pkg::result_t            res;

    logic                        mem_wr_en;
    logic [PTR_W-1:0]            mem_wr_addr;
    logic [EXP_W-1:0]            mem_wr_data;
    logic [PTR_W-1:0]            mem_rd_addr;
    logic [EXP_W-1:0]            mem_rd_data;

    // Config register: always writable; the user must write it only while idle, the block does not enforce this.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shelf_reg <= '0;
        end else if (cfg_valid) begin
            shelf_reg <= cfg_data;
        end
    end

    // Expiry store: one write (produce) and one read (head walk) port.
    efm_ram #(
        .WIDTH (EXP_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Sequencer: pointers, count, sticky flag, pop walk, output register.
    efm_core #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS),
        .EXP_W     (EXP_W)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_event_time (s_event_time),
        .shelf_life   (shelf_reg),
        .res_valid    (m_valid),
        .res_ready    (m_ready),
        .res          (res),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data)
    );

    assign m_status        = res.status;
    assign m_dropped_count = res.dropped_count;
    assign m_occupancy     = res.occupancy;
    assign m_all_served    = res.all_served;

    // RAM is written only on an accepted produce beat.
    a_write_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> (s_valid && s_ready && (s_mode == efm_pkg::MODE_PRODUCE)))
        else $error("expiry write without accepted produce");

    // Produce results never report drops.
    a_no_drop_on_produce: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && ((m_status == efm_pkg::STAT_STORED) ||
                     (m_status == efm_pkg::STAT_OVERFLOW))) |-> (m_dropped_count == '0))
        else $error("drop count on produce result");

    // An unserved consume must show the sticky flag cleared.
    a_unserved_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == efm_pkg::STAT_UNSERVED)) |-> !m_all_served)
        else $error("all_served set on unserved result");

endmodule

/* design/efm_ram.sv */
module efm_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/efm_core.sv */
module efm_core #(
    parameter int DEPTH     = 128,
    parameter int TIME_BITS = 16,
    parameter int EXP_W     = 17
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_mode,
    input  logic [TIME_BITS-1:0]          s_event_time,
    input  logic [efm_pkg::SHELF_W-1:0]   shelf_life,
    output logic                          res_valid,
    input  logic                          res_ready,
    output efm_pkg::result_t              res,
    output logic                          mem_wr_en,
    output logic [$clog2(DEPTH)-1:0]      mem_wr_addr,
    output logic [EXP_W-1:0]              mem_wr_data,
    output logic [$clog2(DEPTH)-1:0]      mem_rd_addr,
    input  logic [EXP_W-1:0]              mem_rd_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]                    state_reg,  state_next;
    logic [PTR_W-1:0]              head_reg,   head_next;
    logic [PTR_W-1:0]              tail_reg,   tail_next;
    logic [CNT_W-1:0]              count_reg,  count_next;
    logic                          served_reg, served_next;
    logic [TIME_BITS-1:0]          time_reg,   time_next;
    logic [CNT_W-1:0]              drop_reg,   drop_next;
    logic [efm_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic                          out_valid_reg, out_valid_next;
    efm_pkg::result_t              out_reg, out_next;

    logic                          accept;
    logic                          fresh;
    logic                          out_free;
    logic [CNT_W+7:0]              drop_wide;
    logic [CNT_W+7:0]              count_wide;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        ring_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign fresh     = (mem_rd_data >= EXP_W'(time_reg));
    assign out_free  = !out_valid_reg || res_ready;
    assign drop_wide  = {8'd0, drop_reg};
    assign count_wide = {8'd0, count_reg};

    assign mem_wr_en   = accept && (s_mode == efm_pkg::MODE_PRODUCE)
                         && (count_reg != CNT_W'(DEPTH));
    assign mem_wr_addr = tail_reg;
    assign mem_wr_data = EXP_W'(s_event_time) + EXP_W'(shelf_life);
    // Read always targets the head after this cycle's pop, so the next
    // head entry is on mem_rd_data in the following cycle.
    assign mem_rd_addr = head_next;

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        served_next    = served_reg;
        time_next      = time_reg;
        drop_next      = drop_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    time_next = s_event_time;
                    drop_next = '0;
                    state_next = ST_HOLD;
                    if (s_mode == efm_pkg::MODE_PRODUCE) begin
                        if (count_reg == CNT_W'(DEPTH)) begin
                            status_next = efm_pkg::STAT_OVERFLOW;
                        end else begin
                            status_next = efm_pkg::STAT_STORED;
                            tail_next   = ring_next(tail_reg);
                            count_next  = count_reg + 1'b1;
                        end
                    end else if (count_reg == '0) begin
                        status_next = efm_pkg::STAT_UNSERVED;
                        served_next = 1'b0;
                    end else begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                head_next  = ring_next(head_reg);
                count_next = count_reg - 1'b1;
                if (fresh) begin
                    status_next = efm_pkg::STAT_SERVED;
                    state_next  = ST_HOLD;
                end else begin
                    drop_next = drop_reg + 1'b1;
                    if (count_reg == CNT_W'(1)) begin
                        status_next = efm_pkg::STAT_UNSERVED;
                        served_next = 1'b0;
                        state_next  = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    out_valid_next         = 1'b1;
                    out_next.status        = status_reg;
                    out_next.dropped_count = drop_wide[7:0];
                    out_next.occupancy     = count_wide[7:0];
                    out_next.all_served    = served_reg;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            served_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            served_reg    <= served_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        time_reg   <= time_next;
        drop_reg   <= drop_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule
